### hw/rtl/vna_pkg.sv
// vna_pkg: shared types and constants for the vertex normal accumulator
// no dependencies

package vna_pkg;

  localparam int unsigned VertexCount = 1024;
  localparam int unsigned CoordBits   = 16;
  localparam int unsigned SumBits     = 40;
  localparam int unsigned IndexBits   = 10;
  localparam int unsigned OutBits     = 16;

  typedef enum logic [1:0] {
    ActLoad = 2'd0,
    ActFace = 2'd1,
    ActRead = 2'd2,
    ActNone = 2'd3
  } action_e;

endpackage

### hw/rtl/vertex_normal_accumulator.sv
// vertex_normal_accumulator: top level, stores, face sequencer and normaliser
// depends on vna_pkg, vna_divider, vna_sqrt

// One item at a time; a new beat is accepted only after the last one is
// finished. A face reads three corner positions from the single-port
// position memory, forms the cross product over a shared 32x32 multiplier
// (six products), then does three read-modify-writes on the accumulator
// memory. A read fetches the three sums, finds the scale, squares through
// the shared multiplier, takes a bit-serial square root and three serial
// divides, and its result may then wait for the output register to free
// up. A read of a zero normal skips the root and divides. After reset a
// clearing pass writes zero to every accumulator entry, one per cycle,
// while in_ready_o is low. A load and an unused action both pass through
// the drop state before the block is idle again.

module vertex_normal_accumulator #(
  parameter int unsigned VERTEX_COUNT = vna_pkg::VertexCount,
  parameter int unsigned SUM_BITS     = vna_pkg::SumBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [9:0]  index_a_i,
  input  logic [9:0]  index_b_i,
  input  logic [9:0]  index_c_i,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic signed [15:0] coord_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  vertex_index_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic        degenerate_o
);
  // coordinate width is tied to the 16-bit coordinate ports
  localparam int unsigned COORD_BITS = vna_pkg::CoordBits;
  localparam int unsigned AW   = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int unsigned DW   = COORD_BITS + 1;   // edge component
  localparam int unsigned PW   = 2 * DW;           // product
  localparam int unsigned CW   = PW + 1;           // cross component
  localparam int unsigned MW   = 30;               // scaled magnitude
  localparam int unsigned SW   = 2 * MW + 2;       // sum of squares
  localparam int unsigned RW   = SW / 2;
  localparam int unsigned NW   = MW + 15;          // dividend
  localparam int unsigned MAGW = SUM_BITS;         // magnitude bits
  localparam int unsigned SHW  = $clog2(MAGW + 1);
  localparam logic signed [SUM_BITS-1:0] SumMax = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SumMin = {1'b1, {(SUM_BITS-1){1'b0}}};

  typedef enum logic [4:0] {
    StClear, StIdle, StDrop,
    StFRd, StFWait, StFMul, StFCross, StFAccRd, StFAccWait, StFAccWr,
    StRRd, StRWait, StRMag, StRShift, StRSq, StRSqAdd, StRSqrt, StRDivGo,
    StRDiv, StROut
  } state_e;

  state_e state_q;

  // memories
  logic [3*COORD_BITS-1:0] pos_mem [VERTEX_COUNT];
  logic [3*SUM_BITS-1:0]   acc_mem [VERTEX_COUNT];
  logic [3*COORD_BITS-1:0] pos_rd_q;
  logic [3*SUM_BITS-1:0]   acc_rd_q;

  logic [AW-1:0]  idx_q [3];
  logic [AW-1:0]  clr_q;
  logic [1:0]     k_q;
  logic [2:0]     m_q;
  logic signed [COORD_BITS-1:0] p_q [3][3];
  logic signed [CW-1:0] cross_q [3];
  logic signed [PW-1:0] prod_q [6];
  logic [MAGW-1:0] mag_q [3];
  logic [2:0]      neg_q;
  logic [SW-1:0]   ssq_q;
  logic [63:0]     sq_q;
  logic [RW-1:0]   root_q;
  logic [15:0]     res_q [3];
  logic            deg_q;

  // position memory port
  logic               pos_we, pos_re;
  logic [AW-1:0]      pos_addr;
  // accumulator memory port
  logic               acc_we, acc_re;
  logic [AW-1:0]      acc_addr;
  logic [3*SUM_BITS-1:0] acc_wdata;

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_addr] <= {coord_x_i[COORD_BITS-1:0],
                                      coord_y_i[COORD_BITS-1:0],
                                      coord_z_i[COORD_BITS-1:0]};
    if (pos_re) pos_rd_q <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_addr] <= acc_wdata;
    if (acc_re) acc_rd_q <= acc_mem[acc_addr];
  end

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  function automatic logic [AW-1:0] idx_of(input logic [9:0] v);
    logic [31:0] w;
    w = 32'(v) % VERTEX_COUNT;
    return w[AW-1:0];
  endfunction

  // shared multiplier operands
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [DW-1:0] ab [3], bc [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab[i] = DW'(p_q[1][i]) - DW'(p_q[0][i]);
      bc[i] = DW'(p_q[2][i]) - DW'(p_q[1][i]);
    end
  end

  // products: 0 ab1*bc2, 1 ab2*bc1, 2 ab2*bc0, 3 ab0*bc2, 4 ab0*bc1, 5 ab1*bc0
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == StRSq) begin
      mul_a = 32'(signed'({2'b00, MW'(mag_q[k_q])}));
      mul_b = mul_a;
    end else begin
      unique case (m_q)
        3'd0: begin mul_a = 32'(ab[1]); mul_b = 32'(bc[2]); end
        3'd1: begin mul_a = 32'(ab[2]); mul_b = 32'(bc[1]); end
        3'd2: begin mul_a = 32'(ab[2]); mul_b = 32'(bc[0]); end
        3'd3: begin mul_a = 32'(ab[0]); mul_b = 32'(bc[2]); end
        3'd4: begin mul_a = 32'(ab[0]); mul_b = 32'(bc[1]); end
        default: begin mul_a = 32'(ab[1]); mul_b = 32'(bc[0]); end
      endcase
    end
  end

  // saturating update of one fetched entry
  logic signed [SUM_BITS-1:0] acc_old [3];
  logic signed [SUM_BITS-1:0] acc_new [3];
  logic signed [SUM_BITS+CW:0] wide;
  always_comb begin
    wide = '0;
    for (int i = 0; i < 3; i++) begin
      acc_old[i] = acc_rd_q[(2-i)*SUM_BITS +: SUM_BITS];
      wide = (SUM_BITS+CW+1)'(acc_old[i]) + (SUM_BITS+CW+1)'(cross_q[i]);
      if (wide > (SUM_BITS+CW+1)'(SumMax)) acc_new[i] = SumMax;
      else if (wide < (SUM_BITS+CW+1)'(SumMin)) acc_new[i] = SumMin;
      else acc_new[i] = wide[SUM_BITS-1:0];
    end
  end

  // scale: leading bit of the largest magnitude
  logic [MAGW-1:0] mx;
  logic [SHW-1:0]  nbits, sh;
  always_comb begin
    mx = mag_q[0];
    if (mag_q[1] > mx) mx = mag_q[1];
    if (mag_q[2] > mx) mx = mag_q[2];
    nbits = '0;
    for (int i = 0; i < MAGW; i++) if (mx[i]) nbits = SHW'(i + 1);
    sh = (nbits > SHW'(MW)) ? nbits - SHW'(MW) : '0;
  end

  // root and division units
  logic sq_start, sq_done, dv_start, dv_done;
  logic [RW-1:0] sq_root;
  logic [NW-1:0] dv_num, dv_quo;
  logic [RW-1:0] dv_den;

  vna_sqrt #(.InBits(SW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(ssq_q),
    .done_o(sq_done), .root_o(sq_root)
  );

  assign dv_num = {MW'(mag_q[k_q]), 14'd0} + NW'(root_q >> 1);
  assign dv_den = root_q;

  vna_divider #(.NumBits(NW), .DenBits(RW)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  assign sq_start = (state_q == StRSqrt) && (k_q == 2'd0) && (m_q == 3'd0);
  assign dv_start = (state_q == StRDivGo);

  logic [15:0] q_clip;
  assign q_clip = (dv_quo > NW'(16384)) ? 16'd16384 : dv_quo[15:0];

  // memory port selection
  always_comb begin
    pos_we = 1'b0; pos_re = 1'b0; pos_addr = idx_q[k_q];
    acc_we = 1'b0; acc_re = 1'b0; acc_addr = idx_q[k_q];
    acc_wdata = {acc_new[0], acc_new[1], acc_new[2]};
    unique case (state_q)
      StClear: begin
        acc_we = 1'b1; acc_addr = clr_q; acc_wdata = '0;
      end
      StIdle: begin
        pos_addr = idx_of(index_a_i);
        pos_we = in_acc && (action_i == vna_pkg::ActLoad);
      end
      StFRd:    pos_re = 1'b1;
      StFAccRd, StRRd: acc_re = 1'b1;
      StFAccWr: acc_we = 1'b1;
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      k_q         <= '0;
      m_q         <= '0;
      out_valid_o <= 1'b0;
    end else begin
      // the output stage handles its own beat while a result is being placed
      if (out_valid_o && out_ready_i && state_q != StROut) out_valid_o <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == VERTEX_COUNT - 1) state_q <= StIdle;
        end
        StIdle: begin
          k_q <= '0;
          m_q <= '0;
          if (in_acc) begin
            unique case (action_i)
              vna_pkg::ActFace: state_q <= StFRd;
              vna_pkg::ActRead: state_q <= StRRd;
              default:          state_q <= StDrop;
            endcase
          end
        end
        StDrop: state_q <= StIdle;
        StFRd:   state_q <= StFWait;
        StFWait: begin
          if (k_q == 2'd2) begin
            k_q <= '0;
            state_q <= StFMul;
          end else begin
            k_q <= k_q + 1'b1;
            state_q <= StFRd;
          end
        end
        StFMul: begin
          m_q <= m_q + 1'b1;
          if (m_q == 3'd5) state_q <= StFCross;
        end
        StFCross: state_q <= StFAccRd;
        StFAccRd: state_q <= StFAccWait;
        StFAccWait: state_q <= StFAccWr;
        StFAccWr: begin
          if (k_q == 2'd2) state_q <= StIdle;
          else begin
            k_q <= k_q + 1'b1;
            state_q <= StFAccRd;
          end
        end
        StRRd:   state_q <= StRWait;
        StRWait: state_q <= StRMag;
        StRMag:  state_q <= (mag_q[0] == '0 && mag_q[1] == '0 && mag_q[2] == '0)
                            ? StROut : StRShift;
        StRShift: state_q <= StRSq;
        StRSq:    state_q <= StRSqAdd;
        StRSqAdd: begin
          if (k_q == 2'd2) begin
            k_q <= '0;
            state_q <= StRSqrt;
          end else begin
            k_q <= k_q + 1'b1;
            state_q <= StRSq;
          end
        end
        StRSqrt: begin
          m_q <= 3'd1;
          if (sq_done) state_q <= StRDivGo;
        end
        StRDivGo: state_q <= StRDiv;
        StRDiv: begin
          if (dv_done) begin
            if (k_q == 2'd2) state_q <= StROut;
            else begin
              k_q <= k_q + 1'b1;
              state_q <= StRDivGo;
            end
          end
        end
        StROut: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (in_acc) begin
        idx_q[0] <= idx_of(index_a_i);
        idx_q[1] <= idx_of(index_b_i);
        idx_q[2] <= idx_of(index_c_i);
        ssq_q    <= '0;
        deg_q    <= 1'b0;
      end
      StFWait: for (int i = 0; i < 3; i++)
        p_q[k_q][i] <= pos_rd_q[(2-i)*COORD_BITS +: COORD_BITS];
      StFMul: prod_q[m_q] <= mul_p[PW-1:0];
      StFCross: begin
        cross_q[0] <= CW'(prod_q[0]) - CW'(prod_q[1]);
        cross_q[1] <= CW'(prod_q[2]) - CW'(prod_q[3]);
        cross_q[2] <= CW'(prod_q[4]) - CW'(prod_q[5]);
      end
      StRWait: for (int i = 0; i < 3; i++) begin
        neg_q[i] <= acc_rd_q[(3-i)*SUM_BITS-1];
        mag_q[i] <= acc_rd_q[(3-i)*SUM_BITS-1]
                    ? MAGW'(-acc_rd_q[(2-i)*SUM_BITS +: SUM_BITS])
                    : acc_rd_q[(2-i)*SUM_BITS +: SUM_BITS];
      end
      StRMag: deg_q <= (mag_q[0] == '0 && mag_q[1] == '0 && mag_q[2] == '0);
      StRShift: for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> sh;
      StRSq:    sq_q <= mul_p;
      StRSqAdd: ssq_q <= ssq_q + sq_q[SW-1:0];
      StRSqrt:  if (sq_done) root_q <= sq_root;
      StRDiv: if (dv_done) res_q[k_q] <= neg_q[k_q] ? 16'(-q_clip) : q_clip;
      StROut: if (!out_valid_o || out_ready_i) begin
        vertex_index_o <= 10'(idx_q[0]);
        degenerate_o   <= deg_q;
        normal_x_o     <= deg_q ? '0 : res_q[0];
        normal_y_o     <= deg_q ? '0 : res_q[1];
        normal_z_o     <= deg_q ? '0 : res_q[2];
      end
      default: ;
    endcase
  end
endmodule

### hw/rtl/vna_divider.sv
// vna_divider: restoring unsigned divider, one quotient bit per cycle
// depends on nothing

module vna_divider #(
  parameter int unsigned NumBits = 45,
  parameter int unsigned DenBits = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quo_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [DenBits:0]   rem_q, rem_d;
  logic [NumBits-1:0] quo_q, quo_d;
  logic [DenBits-1:0] den_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DenBits+1:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[NumBits-1]} - {2'b00, den_q};
      if (!trial[DenBits+1]) begin
        rem_d = trial[DenBits:0];
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DenBits-1:0], quo_q[NumBits-1]};
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

### hw/rtl/vna_sqrt.sv
// vna_sqrt: bit-pair integer square root, one result bit per cycle
// depends on nothing

module vna_sqrt #(
  parameter int unsigned InBits = 62
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [InBits-1:0]   rad_i,
  output logic                done_o,
  output logic [InBits/2-1:0] root_o
);
  localparam int unsigned RootBits = InBits / 2;
  localparam int unsigned CntBits  = $clog2(RootBits + 1);

  logic [InBits-1:0]   rad_q;
  logic [RootBits+1:0] rem_q;
  logic [RootBits-1:0] root_q;
  logic [CntBits-1:0]  cnt_q;
  logic                busy_q, done_q;
  logic [RootBits+1:0] rem_sh, trial;

  assign rem_sh = {rem_q[RootBits-1:0], rad_q[InBits-1:InBits-2]};
  assign trial  = rem_sh - {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(RootBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[InBits-3:0], 2'b00};
      if (!trial[RootBits+1]) begin
        rem_q  <= trial;
        root_q <= {root_q[RootBits-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RootBits-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

### hw/rtl/vna_checker.sv
// vna_checker: port-level assertions for vertex_normal_accumulator
// depends on vna_pkg; bound to the top level

module vna_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  action_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic signed [15:0] normal_x_o,
  input logic signed [15:0] normal_y_o,
  input logic signed [15:0] normal_z_o,
  input logic        degenerate_o
);
  // a beat waiting at the output holds steady
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(normal_x_o))
    else $error("output beat changed while stalled");

  // one item in flight: accepting blocks the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice back to back");

  // a load never yields a result soon after
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == vna_pkg::ActLoad && !out_valid_o
    |=> !out_valid_o)
    else $error("result appeared after a load");

  // degenerate reports are all zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate beat with non-zero normal");
endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);

### sim/tb.sv
// tb: self-checking testbench for vertex_normal_accumulator
// depends on vna_pkg and the vertex_normal_accumulator rtl
`timescale 1ns / 100ps

module tb;
  import vna_pkg::*;

  localparam int unsigned NVert = 1024;
  localparam int unsigned CycleLimit = 2000000;

  // one expected normal beat
  typedef struct {
    logic [9:0]         vidx;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  int unsigned mismatches = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // scoreboard: mirrors the stores and keeps the queue of pending normals
  class normal_board;
    longint pos_x[NVert];
    longint pos_y[NVert];
    longint pos_z[NVert];
    longint acc_x[NVert];
    longint acc_y[NVert];
    longint acc_z[NVert];
    normal_t pending[$];

    function void clear();
      for (int i = 0; i < NVert; i++) begin
        pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
        acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
      end
    endfunction

    function longint sat(longint s);
      longint hi;
      hi = (longint'(1) <<< (SumBits - 1)) - 1;
      if (s > hi) return hi;
      if (s < -hi - 1) return -hi - 1;
      return s;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic signed [15:0] scale(longint s, longint unsigned m, longint unsigned l);
      longint unsigned q;
      q = ((m << 14) + (l >> 1)) / l;
      if (q > 16384) q = 16384;
      if (s < 0) q = -q;
      return q[15:0];
    endfunction

    function void note(action_e act, logic [9:0] a, logic [9:0] b, logic [9:0] c,
                       logic signed [15:0] x, logic signed [15:0] y,
                       logic signed [15:0] z);
      longint abx, aby, abz, bcx, bcy, bcz, fx, fy, fz;
      longint unsigned m[3], mx, ss, l;
      longint sv[3];
      int bits, sh;
      normal_t e;
      case (act)
        ActLoad: begin
          pos_x[a] = x; pos_y[a] = y; pos_z[a] = z;
        end
        ActFace: begin
          abx = pos_x[b] - pos_x[a]; aby = pos_y[b] - pos_y[a]; abz = pos_z[b] - pos_z[a];
          bcx = pos_x[c] - pos_x[b]; bcy = pos_y[c] - pos_y[b]; bcz = pos_z[c] - pos_z[b];
          fx = aby * bcz - abz * bcy;
          fy = abz * bcx - abx * bcz;
          fz = abx * bcy - aby * bcx;
          // corners added in order, so a repeated corner gets it twice
          acc_x[a] = sat(acc_x[a] + fx); acc_y[a] = sat(acc_y[a] + fy);
          acc_z[a] = sat(acc_z[a] + fz);
          acc_x[b] = sat(acc_x[b] + fx); acc_y[b] = sat(acc_y[b] + fy);
          acc_z[b] = sat(acc_z[b] + fz);
          acc_x[c] = sat(acc_x[c] + fx); acc_y[c] = sat(acc_y[c] + fy);
          acc_z[c] = sat(acc_z[c] + fz);
        end
        ActRead: begin
          sv[0] = acc_x[a]; sv[1] = acc_y[a]; sv[2] = acc_z[a];
          e.vidx = a;
          mx = 0;
          for (int k = 0; k < 3; k++) begin
            m[k] = (sv[k] < 0) ? -sv[k] : sv[k];
            if (m[k] > mx) mx = m[k];
          end
          if (mx == 0) begin
            e.nx = 0; e.ny = 0; e.nz = 0; e.degen = 1'b1;
          end else begin
            bits = 0;
            while (bits < 64 && (mx >> bits) != 0) bits++;
            sh = (bits > 30) ? bits - 30 : 0;
            ss = 0;
            for (int k = 0; k < 3; k++) begin
              m[k] >>= sh;
              ss += m[k] * m[k];
            end
            l = root(ss);
            e.nx = scale(sv[0], m[0], l);
            e.ny = scale(sv[1], m[1], l);
            e.nz = scale(sv[2], m[2], l);
            e.degen = 1'b0;
          end
          pending.push_back(e);
        end
        default: ;
      endcase
    endfunction

    task check(logic [9:0] vi, logic signed [15:0] x, logic signed [15:0] y,
               logic signed [15:0] z, logic d);
      normal_t e;
      if (pending.size() == 0) begin
        report("unexpected beat, vertex", vi, -1);
        return;
      end
      e = pending.pop_front();
      if (vi !== e.vidx) report("vertex_index", vi, e.vidx);
      if (x !== e.nx) report("normal_x", x, e.nx);
      if (y !== e.ny) report("normal_y", y, e.ny);
      if (z !== e.nz) report("normal_z", z, e.nz);
      if (d !== e.degen) report("degenerate", d, e.degen);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] action_i = '0;
  logic [9:0] index_a_i = '0, index_b_i = '0, index_c_i = '0;
  logic signed [15:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [9:0] vertex_index_o;
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o;
  logic degenerate_o;

  always #10 clk_i = ~clk_i;

  vertex_normal_accumulator uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .index_a_i, .index_b_i,
    .index_c_i, .coord_x_i, .coord_y_i, .coord_z_i, .out_valid_o, .out_ready_i,
    .vertex_index_o, .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  normal_board board = new();

  // vertices loaded so far; random faces use only these, random reads mostly
  logic [9:0] loaded[$];
  bit         is_loaded[NVert];
  bit         stim_done = 1'b0;
  bit         hold_rx = 1'b0;

  // one beat to the block: set up on a falling edge, hold until accepted
  // valid is written immediately so a beat that follows at once keeps it high
  task automatic send(action_e act, logic [9:0] a, logic [9:0] b, logic [9:0] c,
                      logic signed [15:0] x, logic signed [15:0] y,
                      logic signed [15:0] z, input bit gap = 1'b1);
    int unsigned idle;
    idle = gap ? $urandom_range(0, 7) : 0;
    repeat (idle) @(negedge clk_i);
    action_i <= act; index_a_i <= a; index_b_i <= b; index_c_i <= c;
    coord_x_i <= x; coord_y_i <= y; coord_z_i <= z;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note(act, a, b, c, x, y, z);
    if (act == ActLoad && !is_loaded[a]) begin
      is_loaded[a] = 1'b1;
      loaded.push_back(a);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic load_vertex(logic [9:0] a, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    send(ActLoad, a, 10'd0, 10'd0, x, y, z);
  endtask

  // face or read with noise on the unused coordinate fields
  task automatic send_op(action_e act, logic [9:0] a, logic [9:0] b, logic [9:0] c,
                         input bit gap = 1'b1);
    send(act, a, b, c, 16'($urandom), 16'($urandom), 16'($urandom), gap);
  endtask

  function automatic logic [9:0] pick_loaded();
    return loaded[$urandom_range(0, loaded.size() - 1)];
  endfunction

  function automatic logic signed [15:0] rand_coord();
    // mostly small meshes, sometimes full range so sums grow large
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic wait_drained();
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  // receiver: random stalls per beat, plus one long hold-off on request
  initial begin : receiver
    int unsigned idle;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        out_ready_i <= 1'b0;
        repeat (1500) @(negedge clk_i);
        hold_rx = 1'b0;
      end
      idle = $urandom_range(0, 7);
      if (idle != 0 && $urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b0;
        repeat (idle) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // monitor at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check(vertex_index_o, normal_x_o, normal_y_o, normal_z_o, degenerate_o);
  end

  // watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [9:0] a, b, c;
    int unsigned r;
    board.clear();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every action, degenerate and large-sum cases
    send_op(ActRead, 10'd0, 10'd0, 10'd0);                // zero normal
    load_vertex(10'd0, 16'sh8000, 16'sh8000, 16'sh8000);
    load_vertex(10'd1023, 16'sh7fff, 16'sh8000, 16'sh7fff);
    load_vertex(10'd512, 16'sh8000, 16'sh7fff, 16'sh7fff);
    load_vertex(10'd1, 16'sd0, 16'sd0, 16'sd0);
    load_vertex(10'd2, 16'sd100, 16'sd0, 16'sd0);
    load_vertex(10'd3, 16'sd0, 16'sd100, 16'sd0);
    send_op(ActFace, 10'd1, 10'd2, 10'd3);
    send_op(ActRead, 10'd1, 10'd0, 10'd0);
    send_op(ActFace, 10'd0, 10'd1023, 10'd512);
    send_op(ActRead, 10'd1023, 10'd0, 10'd0);
    repeat (6) send_op(ActFace, 10'd512, 10'd0, 10'd1023); // repeat a full-range face to build large sums
    send_op(ActRead, 10'd512, 10'd0, 10'd0);
    send_op(ActFace, 10'd2, 10'd2, 10'd3);                 // repeated corner
    send_op(ActRead, 10'd2, 10'd0, 10'd0);
    send(ActNone, 10'h3ff, 10'h3ff, 10'h3ff, 16'shffff, 16'shffff, 16'shffff);
    send_op(ActRead, 10'd0, 10'h3ff, 10'h3ff);
    send_op(ActRead, 10'd3, 10'd0, 10'd0);

    // random: mostly well-formed loads, faces and reads over loaded vertices
    for (int i = 0; i < 400; i++) begin
      if (i == 150) begin
        // long receiver hold-off while reads keep coming, so the block backs up
        hold_rx = 1'b1;
        repeat (12) send_op(ActRead, pick_loaded(), 10'd0, 10'd0, 1'b0);
      end
      if (i == 300) wait_drained();                        // sender pause
      r = $urandom_range(0, 99);
      if (r < 25 || loaded.size() < 3) begin
        // low index bits widely spread, sometimes a small reused set
        a = ($urandom_range(0, 1)) ? 10'($urandom) : 10'($urandom_range(0, 15));
        load_vertex(a, rand_coord(), rand_coord(), rand_coord());
      end else if (r < 65) begin
        a = pick_loaded(); b = pick_loaded(); c = pick_loaded();
        send_op(ActFace, a, b, c);
      end else if (r < 95) begin
        // reading an unloaded vertex is fine: its sums are defined
        a = ($urandom_range(0, 3) == 0) ? 10'($urandom) : pick_loaded();
        send_op(ActRead, a, 10'($urandom), 10'($urandom));
      end else begin
        send(ActNone, 10'($urandom), 10'($urandom), 10'($urandom),
             16'($urandom), 16'($urandom), 16'($urandom));
      end
    end

    wait_drained();
    repeat (400) @(negedge clk_i);
    if (mismatches == 0 && board.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
